// File: hdl/lts_pkg.sv
// shared types and constants for the linear trend slope block
// used by lts_ctrl, lts_datapath and linear_trend_slope; no dependencies
package lts_pkg;

	localparam int MAX_WINDOW    = 1024;
	localparam int SAMPLE_BITS   = 24;
	localparam int SLOPE_BITS    = 40;
	localparam int FRAC_BITS     = 16;
	localparam int CFG_BITS      = 11;
	localparam int WINDOW_RESET  = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS,
		ST_SCALE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic cfg_wr;
		logic abs_ld;
		logic scale_ld;
		logic div_step;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic row_end;
		logic n_one;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

// File: hdl/lts_ctrl.sv
// controller state machine for the linear trend slope block
// sequences accumulate, magnitude, scale, divide and output; uses lts_pkg
module lts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  lts_pkg::status_t  status,
	output lts_pkg::cmd_t     cmd
);

	lts_pkg::state_t state_q;
	lts_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lts_pkg::ST_IDLE: begin
				// config write wins over a sample in the same cycle
				if (sample_valid && !cfg_valid) begin
					if (status.n_one) begin
						state_d = lts_pkg::ST_DONE;
					end else if (status.row_end) begin
						state_d = lts_pkg::ST_ABS;
					end
				end
			end
			lts_pkg::ST_ABS:   state_d = lts_pkg::ST_SCALE;
			lts_pkg::ST_SCALE: state_d = lts_pkg::ST_DIV;
			lts_pkg::ST_DIV: begin
				if (status.div_last) begin
					state_d = lts_pkg::ST_DONE;
				end
			end
			lts_pkg::ST_DONE: begin
				if (status.out_free) begin
					state_d = lts_pkg::ST_IDLE;
				end
			end
			default: state_d = lts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		sample_stall = 1'b1;
		cfg_ready    = 1'b0;
		case (state_q)
			lts_pkg::ST_IDLE: begin
				sample_stall = cfg_valid;
				cfg_ready    = 1'b1;
				cmd.cfg_wr   = cfg_valid;
				cmd.accept   = sample_valid && !cfg_valid;
			end
			lts_pkg::ST_ABS:   cmd.abs_ld   = 1'b1;
			lts_pkg::ST_SCALE: cmd.scale_ld = 1'b1;
			lts_pkg::ST_DIV:   cmd.div_step = 1'b1;
			lts_pkg::ST_DONE:  cmd.out_ld   = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// File: hdl/lts_datapath.sv
// datapath for the linear trend slope block: position counter, weighted
// accumulator, restoring divider and saturating output word; uses lts_pkg
module lts_datapath #(
	parameter int MAX_WINDOW  = lts_pkg::MAX_WINDOW,
	parameter int SAMPLE_BITS = lts_pkg::SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lts_pkg::cmd_t                         cmd,
	output lts_pkg::status_t                      status,
	input  logic [lts_pkg::CFG_BITS-1:0]          window_length,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic                                  slope_stall,
	output logic                                  slope_valid,
	output logic signed [lts_pkg::SLOPE_BITS-1:0] slope
);

	localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int NW      = $clog2(MAX_WINDOW + 1);
	localparam int WW      = AW + 2;
	localparam int PW      = WW + SAMPLE_BITS;
	localparam int ACC_W   = 2 * AW + SAMPLE_BITS + 2;
	localparam int MAG_W   = ACC_W + 3;
	localparam int SH      = lts_pkg::FRAC_BITS + 1;
	localparam int NUM_W   = MAG_W + SH;
	localparam int DW      = 3 * NW;
	localparam int OW      = lts_pkg::SLOPE_BITS;
	localparam int QW      = OW + 1;
	localparam int CW      = $clog2(NUM_W);
	localparam int N_RESET = (lts_pkg::WINDOW_RESET > MAX_WINDOW) ?
		MAX_WINDOW : lts_pkg::WINDOW_RESET;

	logic [NW-1:0]           n_q;
	logic [NW-1:0]           n_d;
	logic [NW-1:0]           nm1;
	logic [AW-1:0]           pos_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [2*NW-1:0]         nsq_q;
	logic [DW-1:0]           d_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        amag_q;
	logic [NUM_W-1:0]        num_q;
	logic [DW-1:0]           rem_q;
	logic [QW-1:0]           quo_q;
	logic                    big_q;
	logic [CW-1:0]           cnt_q;
	logic                    slope_valid_q;
	logic [OW-1:0]           slope_q;

	logic signed [WW-1:0]    w;
	logic signed [PW-1:0]    prod;
	logic signed [ACC_W-1:0] acc_sum;
	logic [SAMPLE_BITS-1:0]  x_abs;
	logic [63:0]             one_mag;
	logic [ACC_W-1:0]        acc_abs;
	logic [MAG_W-1:0]        mag6;
	logic [DW:0]             trial;
	logic [DW:0]             diff;
	logic                    ge;
	logic [QW:0]             rnd;
	logic [QW-1:0]           rmag;
	logic [QW-1:0]           lim;
	logic [OW-1:0]           packed_w;

	// window length zero reads as one, above the maximum as the maximum
	always_comb begin
		if (window_length == '0) begin
			n_d = NW'(1);
		end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
			n_d = NW'(MAX_WINDOW);
		end else begin
			n_d = NW'(window_length);
		end
	end

	assign nm1 = n_q - NW'(1);

	// weight of this point: 2t - (N-1)
	assign w       = $signed({1'b0, pos_q, 1'b0}) - $signed({{(WW-NW){1'b0}}, nm1});
	assign prod    = PW'(w) * PW'(sample);
	assign acc_sum = acc_q + ACC_W'(prod);

	assign x_abs   = sample[SAMPLE_BITS-1] ? $unsigned(-sample) : $unsigned(sample);
	assign one_mag = 64'(x_abs) << lts_pkg::FRAC_BITS;
	assign acc_abs = acc_q[ACC_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
	assign mag6    = MAG_W'({amag_q, 2'b00}) + MAG_W'({amag_q, 1'b0});

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	// quotient carries one extra bit; add one and halve to round the magnitude half up
	assign rnd  = {1'b0, quo_q} + (QW+1)'(1);
	assign rmag = rnd[QW:1];
	assign lim  = QW'(1) << (OW - 1);

	always_comb begin
		if (neg_q) begin
			if (big_q || rmag > lim) begin
				packed_w = {1'b1, {(OW-1){1'b0}}};
			end else begin
				packed_w = -rmag[OW-1:0];
			end
		end else begin
			if (big_q || rmag >= lim) begin
				packed_w = {1'b0, {(OW-1){1'b1}}};
			end else begin
				packed_w = rmag[OW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q           <= NW'(N_RESET);
			pos_q         <= '0;
			acc_q         <= '0;
			slope_valid_q <= 1'b0;
		end else begin
			if (cmd.cfg_wr) begin
				n_q   <= n_d;
				pos_q <= '0;
				acc_q <= '0;
			end else if (cmd.accept && !status.n_one) begin
				acc_q <= acc_sum;
				pos_q <= status.row_end ? '0 : pos_q + AW'(1);
			end else if (cmd.abs_ld) begin
				acc_q <= '0;
			end
			if (cmd.out_ld) begin
				slope_valid_q <= 1'b1;
			end else if (!slope_stall) begin
				slope_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		nsq_q <= (2*NW)'(n_q) * (2*NW)'(n_q);
		d_q   <= DW'(n_q) * DW'(nsq_q - (2*NW)'(1));
		if (cmd.accept && status.n_one) begin
			neg_q <= sample[SAMPLE_BITS-1];
			quo_q <= {one_mag[OW-1:0], 1'b0};
			big_q <= |one_mag[63:OW];
		end
		if (cmd.abs_ld) begin
			neg_q  <= acc_q[ACC_W-1];
			amag_q <= acc_abs;
		end
		if (cmd.scale_ld) begin
			num_q <= {mag6, {SH{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
			cnt_q <= CW'(NUM_W - 1);
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
			big_q <= big_q | quo_q[QW-1];
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.out_ld) begin
			slope_q <= packed_w;
		end
	end

	assign status.row_end  = (pos_q == nm1[AW-1:0]);
	assign status.n_one    = (n_q == NW'(1));
	assign status.div_last = (cnt_q == '0);
	assign status.out_free = !slope_valid_q || !slope_stall;

	assign slope_valid = slope_valid_q;
	assign slope       = $signed(slope_q);

	a_pos_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		NW'(pos_q) < n_q)
		else $error("position counter left the row");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> rem_q < d_q)
		else $error("divider remainder not below divisor");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.abs_ld |=> acc_q == '0 && pos_q == '0)
		else $error("row state not cleared after row end");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> slope_valid)
		else $error("finished slope not presented");

endmodule

// File: hdl/linear_trend_slope.sv
// one sample per cycle inside a row unless a config write stalls it; the row end
//   sample then steps the controller through ST_ABS, ST_SCALE, ST_DIV and ST_DONE,
//   stalling samples; window length one sends each sample straight to ST_DONE
// the restoring divider takes one quotient bit per cycle over NUM_W bits, where
//   NUM_W = 2*clog2(MAX_WINDOW) + SAMPLE_BITS + 22 (66 at defaults)
// reset: position and accumulator cleared, window length 8, no word pending
module linear_trend_slope #(
	parameter int MAX_WINDOW  = lts_pkg::MAX_WINDOW,
	parameter int SAMPLE_BITS = lts_pkg::SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lts_pkg::CFG_BITS-1:0]          window_length,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	output logic                                  slope_valid,
	input  logic                                  slope_stall,
	output logic signed [lts_pkg::SLOPE_BITS-1:0] slope
);

	lts_pkg::cmd_t    cmd;
	lts_pkg::status_t status;

	lts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.status       (status),
		.cmd          (cmd)
	);

	lts_datapath #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.window_length (window_length),
		.sample        (sample),
		.slope_stall   (slope_stall),
		.slope_valid   (slope_valid),
		.slope         (slope)
	);

endmodule
